[rtl/htms_pkg.sv]
package htms_pkg;

  localparam int OUT_BITS_DEF = 16;
  // register stages inside one channel datapath
  localparam int PIPE_STAGES  = 43;
  // quotient bits of the pipelined divider
  localparam int DIV_BITS     = 33;

  localparam logic [1:0] MODE_CLAMP    = 2'd0;
  localparam logic [1:0] MODE_REINHARD = 2'd1;
  localparam logic [1:0] MODE_ACES     = 2'd2;

  localparam logic REG_EXPOSURE = 1'b0;
  localparam logic REG_MAP_MODE = 1'b1;

  typedef struct packed {
    logic [31:0] red_in;
    logic [31:0] green_in;
    logic [31:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
  } pix_out_t;

  typedef struct packed {
    logic [9:0] exposure;
    logic [1:0] map_mode;
  } cfg_t;

  typedef logic [16:0] frac_tab_t [16];
  typedef logic [24:0] root_tab_t [65];
  typedef logic [28:0] stop_tab_t [9];

  // 2^(r/16) in Q1.16
  localparam frac_tab_t EXP2_FRAC = '{
    17'd65536,  17'd68438,  17'd71468,  17'd74632,
    17'd77936,  17'd81386,  17'd84990,  17'd88752,
    17'd92682,  17'd96785,  17'd101070, 17'd105545,
    17'd110218, 17'd115098, 17'd120194, 17'd125515
  };

  function automatic longint unsigned pow12(longint unsigned z);
    longint unsigned z2, z4, z8;
    z2 = (z * z) >> 24;
    z4 = (z2 * z2) >> 24;
    z8 = (z4 * z4) >> 24;
    return (z8 * z4) >> 24;
  endfunction

  // largest Q1.24 z with z^12 <= p
  function automatic longint unsigned root12(longint unsigned p);
    longint unsigned z;
    z = 64'd1 << 24;
    for (int b = 23; b >= 0; b--) begin
      if (pow12(z + (64'd1 << b)) <= p) z = z + (64'd1 << b);
    end
    return z;
  endfunction

  function automatic root_tab_t build_root_tab();
    root_tab_t t;
    longint unsigned m, m2, m4, m5;
    for (int i = 0; i <= 64; i++) begin
      m  = (64'd1 << 24) + (64'(i) << 18);
      m2 = (m * m) >> 24;
      m4 = (m2 * m2) >> 24;
      m5 = (m4 * m) >> 24;
      t[i] = 25'(root12(m5));
    end
    return t;
  endfunction

  function automatic stop_tab_t build_stop_tab();
    stop_tab_t t;
    int s, e;
    longint unsigned d;
    for (int i = 0; i <= 8; i++) begin
      s = (5 * i + 11) / 12;
      e = 12 * s - 5 * i;
      d = root12(64'd1 << (24 + e));
      t[i] = 29'(d << (4 - s));
    end
    return t;
  endfunction

  // x^(5/12) over [1,2] in Q1.24, and 2^(-5k/12) in Q1.28
  localparam root_tab_t ROOT_TAB = build_root_tab();
  localparam stop_tab_t STOP_TAB = build_stop_tab();

endpackage

[rtl/htms_channel.sv]
module htms_channel
  import htms_pkg::*;
#(
  parameter int OUT_BITS = OUT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  cfg_t                cfg_i,
  input  logic [31:0]         x_i,
  output logic [OUT_BITS-1:0] res_o
);

  localparam logic [47:0] VSAT   = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] ONE64  = 64'd1 << 32;
  localparam logic [47:0] ACES_V = 48'h000F_FFFF_FFFF;

  // exposure decode: index of frac table and shift offset by 32
  logic [9:0] u;
  logic [5:0] shamt;
  assign u     = cfg_i.exposure ^ 10'h200;
  assign shamt = u[9:4];

  // S1 gain multiply
  logic [48:0] p_q;
  always_ff @(posedge clk_i) begin
    if (en_i) p_q <= 49'(x_i) * 49'(EXP2_FRAC[u[3:0]]);
  end

  // S2 shift with saturation
  logic [47:0] v_d, v2_q;
  logic [63:0] lim, pl;
  logic [5:0]  rs;
  always_comb begin
    lim = 64'(VSAT) >> shamt[4:0];
    pl  = {15'b0, p_q} << shamt[4:0];
    rs  = 6'd32 - shamt;
    if (shamt[5]) begin
      v_d = ({15'b0, p_q} > lim) ? VSAT : pl[47:0];
    end else begin
      v_d = 48'({15'b0, p_q} >> rs);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) v2_q <= v_d;
  end

  // S3 ACES first products
  logic [47:0] vs;
  logic [27:0] xs;
  logic [45:0] ma_q, mc_q;
  logic [27:0] xs_q;
  logic [47:0] v3_q;
  assign vs = (v2_q > ACES_V) ? ACES_V : v2_q;
  assign xs = vs[35:8];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q <= 46'(18'd164495) * 46'(xs);
      mc_q <= 46'(18'd159252) * 46'(xs);
      xs_q <= xs;
      v3_q <= v2_q;
    end
  end

  // S4 ACES numerator and denominator products
  logic [46:0] s1, s2;
  logic [50:0] num_q, dt_q;
  logic [47:0] v4_q;
  assign s1 = 47'(ma_q) + (47'(1966) << 24);
  assign s2 = 47'(mc_q) + (47'(38666) << 24);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= 51'(s1[46:24]) * 51'(xs_q);
      dt_q  <= 51'(s2[46:24]) * 51'(xs_q);
      v4_q  <= v3_q;
    end
  end

  // S5 divider operands; clamp divides by one
  logic [DIV_BITS-1:0][63:0] rem_q;
  logic [DIV_BITS-1:0][48:0] d_q;
  logic [DIV_BITS-1:0]       inv_q;
  logic [DIV_BITS-1:1][32:0] q_q;
  logic [63:0] n_d;
  logic [48:0] dv_d;
  logic        inv_d;
  logic [51:0] den;
  always_comb begin
    den   = 52'(dt_q) + (52'(9175) << 24);
    n_d   = (64'(v4_q) > ONE64) ? ONE64 : 64'(v4_q);
    dv_d  = 49'd1;
    inv_d = 1'b0;
    case (cfg_i.map_mode)
      MODE_REINHARD: begin
        dv_d = 49'(v4_q) + (49'd1 << 32);
        if (v4_q[47:32] == 16'd0) begin
          n_d = {v4_q[31:0], 32'h0};
        end else begin
          n_d   = '1;
          inv_d = 1'b1;
        end
      end
      MODE_ACES: begin
        n_d  = {num_q[49:0], 14'b0};
        dv_d = 49'(den[51:18]);
      end
      MODE_CLAMP: begin
        n_d = (64'(v4_q) > ONE64) ? ONE64 : 64'(v4_q);
      end
      default: begin
        n_d = (64'(v4_q) > ONE64) ? ONE64 : 64'(v4_q);
      end
    endcase
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= n_d;
      d_q[0]   <= dv_d;
      inv_q[0] <= inv_d;
    end
  end

  // restoring divider, one quotient bit per stage
  logic [32:0] q_fin_q;
  logic        inv_fin_q;
  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    localparam int B = DIV_BITS - 1 - j;
    logic [81:0] dsh, rx;
    logic        take;
    logic [32:0] q_n;
    assign dsh  = {33'b0, d_q[j]} << B;
    assign rx   = {18'b0, rem_q[j]};
    assign take = rx >= dsh;
    if (j == 0) begin : g_first
      assign q_n = {32'b0, take};
    end else begin : g_next
      assign q_n = {q_q[j][31:0], take};
    end
    if (j < DIV_BITS - 1) begin : g_mid
      logic [81:0] diff;
      assign diff = rx - dsh;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j+1] <= take ? diff[63:0] : rem_q[j];
          d_q[j+1]   <= d_q[j];
          inv_q[j+1] <= inv_q[j];
          q_q[j+1]   <= q_n;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          q_fin_q   <= q_n;
          inv_fin_q <= inv_q[j];
        end
      end
    end
  end

  // mapped value L in Q1.32
  logic [32:0] l_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (inv_fin_q) l_q <= (33'd1 << 32) - q_fin_q;
      else           l_q <= (q_fin_q > (33'd1 << 32)) ? (33'd1 << 32) : q_fin_q;
    end
  end

  // E1 normalize and table read
  logic [3:0]  k;
  logic [31:0] m;
  logic [6:0]  idx;
  logic [6:0]  idx1;
  always_comb begin
    k = 4'd8;
    for (int j = 7; j >= 0; j--) begin
      if (l_q[31-j]) k = 4'(j);
    end
    m    = l_q[31:0] << k;
    idx  = 7'(m[30:25]);
    idx1 = idx + 7'd1;
  end
  logic [24:0] root_q, diff_q, w_q;
  logic [3:0]  k1_q;
  logic        sat1_q, lin1_q;
  logic [43:0] linp_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q <= ROOT_TAB[idx];
      diff_q <= ROOT_TAB[idx1] - ROOT_TAB[idx];
      w_q    <= m[24:0];
      k1_q   <= k;
      sat1_q <= l_q[32];
      lin1_q <= (l_q <= 33'd13446683);
      linp_q <= 44'(l_q[23:0]) * 44'(20'd846725);
    end
  end

  // E2 interpolation product, linear segment rounding
  logic [49:0] ip_q;
  logic [24:0] root2_q;
  logic [3:0]  k2_q;
  logic        sat2_q, lin2_q;
  logic [11:0] linr2_q;
  logic [44:0] linsum;
  assign linsum = 45'(linp_q) + (45'd1 << 31);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ip_q    <= 50'(diff_q) * 50'(w_q);
      root2_q <= root_q;
      k2_q    <= k1_q;
      sat2_q  <= sat1_q;
      lin2_q  <= lin1_q;
      linr2_q <= linsum[43:32];
    end
  end

  // E3 octave scaling
  logic [24:0] z;
  logic [53:0] yp;
  logic [25:0] y_q;
  logic        sat3_q, lin3_q;
  logic [11:0] linr3_q;
  assign z  = root2_q + ip_q[49:25];
  assign yp = 54'(STOP_TAB[k2_q]) * 54'(z);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q     <= yp[53:28];
      sat3_q  <= sat2_q;
      lin3_q  <= lin2_q;
      linr3_q <= linr2_q;
    end
  end

  // E4 1.055 scale and rounding
  logic [43:0] ts;
  logic [19:0] t_q;
  logic        sat4_q, lin4_q;
  logic [11:0] linr4_q;
  assign ts = 44'(17'd69140) * 44'(y_q) + (44'd1 << 23);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q     <= ts[43:24];
      sat4_q  <= sat3_q;
      lin4_q  <= lin3_q;
      linr4_q <= linr3_q;
    end
  end

  // offset, clamp and select
  logic [19:0] tm;
  logic [15:0] res16;
  always_comb begin
    tm = t_q - 20'd3604;
    if (sat4_q)                res16 = 16'hFFFF;
    else if (lin4_q)           res16 = 16'(linr4_q);
    else if (t_q < 20'd3604)   res16 = 16'd0;
    else if (tm > 20'd65535)   res16 = 16'hFFFF;
    else                       res16 = tm[15:0];
  end
  assign res_o = res16[15 -: OUT_BITS];

endmodule

[rtl/hdr_tone_map_srgb_core.sv]
// HDR tone mapper with sRGB encoding, one RGB pixel per beat.
// Throughput one pixel per cycle when the output is not back-pressured, set by a
// fully pipelined datapath with a 33-stage restoring divider.
// Back pressure stalls the whole pipeline together with the output register.
// Reset (async, active low) clears valid bits, exposure to 0 and mode to clamp.
module hdr_tone_map_srgb_core
  import htms_pkg::*;
#(
  parameter int OUT_BITS = OUT_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pix_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pix_out_t out_data_o,
  input  logic     cfg_we_i,
  input  logic     cfg_index_i,
  input  logic [9:0] cfg_wdata_i
);

  // configuration registers
  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_EXPOSURE: cfg_q.exposure <= cfg_wdata_i;
        REG_MAP_MODE: cfg_q.map_mode <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves when the output slot is free or being drained
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // valid bits ride alongside the datapath stages
  logic [PIPE_STAGES-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[PIPE_STAGES-2:0], in_valid_i};
      out_valid_q <= vld_q[PIPE_STAGES-1];
    end
  end

  // three identical channel datapaths
  logic [OUT_BITS-1:0] r_res, g_res, b_res;

  htms_channel #(.OUT_BITS(OUT_BITS)) u_red (
    .clk_i (clk_i), .en_i (en), .cfg_i (cfg_q),
    .x_i   (in_data_i.red_in), .res_o (r_res)
  );
  htms_channel #(.OUT_BITS(OUT_BITS)) u_green (
    .clk_i (clk_i), .en_i (en), .cfg_i (cfg_q),
    .x_i   (in_data_i.green_in), .res_o (g_res)
  );
  htms_channel #(.OUT_BITS(OUT_BITS)) u_blue (
    .clk_i (clk_i), .en_i (en), .cfg_i (cfg_q),
    .x_i   (in_data_i.blue_in), .res_o (b_res)
  );

  // output register, results zero extended to the 16-bit fields
  pix_out_t out_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.red_out   <= 16'(r_res);
      out_q.green_out <= 16'(g_res);
      out_q.blue_out  <= 16'(b_res);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // an accepted beat enters the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted beat missing from stage 0");

  // stalled pipeline keeps every valid bit
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q) && out_valid_q)
    else $error("pipeline moved during stall");

  // last stage drains into the output register
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[PIPE_STAGES-1] && en) |=> out_valid_q)
    else $error("beat lost at output register");

  // exposure write lands
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_index_i == REG_EXPOSURE) |=> cfg_q.exposure == $past(cfg_wdata_i))
    else $error("exposure write not taken");

endmodule
